// File: sv/b62id_pkg.sv
package b62id_pkg;

  // Id and digit geometry
  localparam int unsigned IdBits    = 32;
  localparam int unsigned MaxDigits = 6;
  localparam int unsigned DigitW    = 6;
  localparam int unsigned CountW    = 3;
  localparam int unsigned CharW     = 8;

  // Reciprocal for x / 31 with x < 2^31: q = (x * RecipMul) >> RecipShift.
  // v / 62 is then (v >> 1) / 31.
  localparam int unsigned RecipShift = 36;
  localparam logic [31:0] RecipMul   = 32'd2216757315;
  localparam int unsigned ProdW      = 63;
  localparam int unsigned QuotW      = ProdW - RecipShift;

  // Queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  // Result kinds
  localparam logic KindChar = 1'b0;
  localparam logic KindId   = 1'b1;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_e;

  typedef struct packed {
    logic              cmd;
    logic [IdBits-1:0] id_value;
    logic [CharW-1:0]  in_char;
    logic              in_last;
  } in_item_t;

  typedef struct packed {
    logic              kind;
    logic [CharW-1:0]  out_char;
    logic [IdBits-1:0] out_id;
    logic              out_last;
  } out_item_t;

  // Classified item as it waits in the queue
  typedef struct packed {
    cmd_e              cmd;
    logic [IdBits-1:0] id_value;
    logic [DigitW-1:0] digit;
    logic              last;
  } work_t;

  // ASCII character to digit; anything outside the alphabet is digit 0
  function automatic logic [DigitW-1:0] char_to_digit(input logic [CharW-1:0] c);
    logic [DigitW-1:0] d;
    d = '0;
    if (c >= 8'h61 && c <= 8'h7a) begin
      d = DigitW'(c - 8'h61);
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      d = DigitW'(c - 8'h41 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = DigitW'(c - 8'h30 + 8'd52);
    end
    return d;
  endfunction

  // Digit 0..61 to its ASCII character
  function automatic logic [CharW-1:0] digit_to_char(input logic [DigitW-1:0] d);
    logic [CharW-1:0] c;
    if (d < 6'd26) begin
      c = 8'h61 + CharW'(d);
    end else if (d < 6'd52) begin
      c = 8'h41 + CharW'(d) - 8'd26;
    end else begin
      c = 8'h30 + CharW'(d) - 8'd52;
    end
    return c;
  endfunction

endpackage

// File: sv/b62id_front.sv
module b62id_front (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  b62id_pkg::in_item_t in_item_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output b62id_pkg::work_t   push_item_o
);
  import b62id_pkg::*;

  // Classify the item and map a character to its digit on the way in
  always_comb begin
    push_item_o.cmd      = cmd_e'(in_item_i.cmd);
    push_item_o.id_value = in_item_i.id_value;
    push_item_o.digit    = char_to_digit(in_item_i.in_char);
    push_item_o.last     = in_item_i.in_last;
  end

  assign push_valid_o = in_valid_i;
  assign in_ready_o   = push_ready_i;

endmodule

// File: sv/b62id_queue.sv
module b62id_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  b62id_pkg::work_t push_item_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output b62id_pkg::work_t pop_item_o
);
  import b62id_pkg::*;

  work_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 push, pop;

  assign push_ready_o = (count_q != QueueCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QueueCntW'(QueueDepth))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) || (count_q == QueueCntW'(QueueDepth)) |-> wr_ptr_q == rd_ptr_q)
    else $error("queue pointers disagree with count");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |=> count_q <= QueueCntW'(1))
    else $error("queue count jumped from empty");

endmodule

// File: sv/b62id_back.sv
module b62id_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  b62id_pkg::work_t    pop_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output b62id_pkg::out_item_t out_item_o
);
  import b62id_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e              state_q;
  logic [IdBits-1:0]   v_q;
  logic [ProdW-1:0]    p_q;
  logic [CountW-1:0]   n_q, k_q;
  logic [DigitW-1:0]   digs_q [MaxDigits];
  logic [IdBits-1:0]   acc_q;
  logic                out_valid_q;
  out_item_t           out_q;

  logic                can_load;
  logic [QuotW-1:0]    quot;
  logic [IdBits-1:0]   quot62;
  logic [DigitW-1:0]   rem;
  logic [30:0]         mul_a;
  logic [ProdW-1:0]    prod;
  logic [IdBits-1:0]   acc_next;
  logic                pop;
  logic                more;
  logic                load_out;

  assign can_load = !out_valid_q || out_ready_i;

  // One digit per cycle: quotient from the registered product, remainder by subtract
  assign quot   = p_q[ProdW-1:RecipShift];
  assign quot62 = (IdBits'(quot) << 6) - (IdBits'(quot) << 1);
  assign rem    = DigitW'(v_q - quot62);
  assign more   = (v_q != '0) && (n_q < CountW'(MaxDigits));

  // Multiplier operand: new id on load, else next quotient
  assign mul_a = (state_q == ST_IDLE) ? pop_item_i.id_value[IdBits-1:1]
                                      : 31'(quot[QuotW-1:1]);
  assign prod  = mul_a * RecipMul;

  // Decode step: acc * 62 + digit, wrapping
  assign acc_next = (acc_q << 6) - (acc_q << 1) + IdBits'(pop_item_i.digit);

  assign pop = (state_q == ST_IDLE) && pop_valid_i &&
               ((pop_item_i.cmd == CMD_ENCODE) || !pop_item_i.last || can_load);
  assign pop_ready_o = pop;

  // Output register takes a new item on a decoded id or an emitted char
  assign load_out = (pop && (pop_item_i.cmd == CMD_DECODE) && pop_item_i.last) ||
                    ((state_q == ST_EMIT) && can_load);

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      k_q         <= '0;
      v_q         <= '0;
      p_q         <= '0;
      digs_q      <= '{default: '0};
      out_q       <= '0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop) begin
            if (pop_item_i.cmd == CMD_ENCODE) begin
              v_q     <= pop_item_i.id_value;
              p_q     <= prod;
              n_q     <= '0;
              state_q <= ST_DIV;
            end else if (pop_item_i.last) begin
              out_q.kind     <= KindId;
              out_q.out_char <= '0;
              out_q.out_id   <= acc_next;
              out_q.out_last <= 1'b1;
              acc_q          <= '0;
            end else begin
              acc_q <= acc_next;
            end
          end
        end
        ST_DIV: begin
          if (more) begin
            digs_q[n_q] <= rem;
            v_q         <= IdBits'(quot);
            p_q         <= prod;
            n_q         <= n_q + 1'b1;
          end else if (n_q == '0) begin
            state_q <= ST_IDLE;
          end else begin
            k_q     <= n_q - 1'b1;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (can_load) begin
            out_q.kind     <= KindChar;
            out_q.out_char <= digit_to_char(digs_q[k_q]);
            out_q.out_id   <= '0;
            out_q.out_last <= (k_q == '0);
            if (k_q == '0) begin
              state_q <= ST_IDLE;
            end else begin
              k_q <= k_q - 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_recip_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (quot62 <= v_q) && ((v_q - quot62) < IdBits'(62)))
    else $error("reciprocal quotient off by one");

  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> n_q <= CountW'(MaxDigits))
    else $error("digit count past limit");

  a_emit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> k_q < n_q)
    else $error("emit index past stored digits");

  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && (pop_item_i.cmd == CMD_DECODE) && pop_item_i.last |=> acc_q == '0)
    else $error("accumulator not cleared after decoded id");

endmodule

// File: sv/base62_id_codec_core.sv
// Channel | valid       | ready       | item
// --------+-------------+-------------+--------------------------------
// in      | in_valid_i  | in_ready_o  | in_item_i  (cmd, id, char, last)
// out     | out_valid_o | out_ready_i | out_item_o (kind, char, id, last)
//
// Decode items are folded into an accumulator as they are popped; an id comes out on the last char.
// Encode makes one digit per cycle from a reciprocal multiply, then the stored
// digits go out most significant first, each as the output register frees up.
// A two-entry queue lets the input side keep accepting, until it fills, while the back end works.
// Reset (rst_ni, async, active low) empties the queue and clears the accumulator.
// The output register holds its item until out_ready_i; a new output item waits meanwhile.
module base62_id_codec_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  b62id_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output b62id_pkg::out_item_t out_item_o
);
  import b62id_pkg::*;

  logic  push_valid, push_ready, pop_valid, pop_ready;
  work_t push_item, pop_item;

  b62id_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  b62id_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  b62id_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_item_i  (pop_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
